// ===== rtl/core/nsf_pkg.sv =====
// ----------------------------------------------------------------------------
// nsf_pkg
// shared constants and the result type of the sentence framer
// ----------------------------------------------------------------------------
package nsf_pkg;

  // payload store depth in bytes
  localparam int BUFFER_BYTES = 128;
  localparam int COUNT_W      = 8;
  localparam int INDEX_W      = 7;

  // framing characters
  localparam logic [7:0] CH_START = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // status codes
  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_DONE        = 4'd1;
  localparam logic [3:0] ST_OVERRUN     = 4'd2;
  localparam logic [3:0] ST_START_EXP   = 4'd3;
  localparam logic [3:0] ST_START_UNEXP = 4'd4;
  localparam logic [3:0] ST_LF_UNEXP    = 4'd5;
  localparam logic [3:0] ST_CR_UNEXP    = 4'd6;
  localparam logic [3:0] ST_TOO_LONG    = 4'd7;
  localparam logic [3:0] ST_BAD_HEX     = 4'd8;
  localparam logic [3:0] ST_CSUM_BAD    = 4'd9;
  localparam logic [3:0] ST_CR_EXP      = 4'd10;
  localparam logic [3:0] ST_LF_EXP      = 4'd11;

  typedef struct packed {
    logic [3:0]         status;
    logic               payload_valid;
    logic [7:0]         payload_byte;
    logic [INDEX_W-1:0] payload_index;
    logic [COUNT_W-1:0] sentence_length;
  } nsf_result_t;

endpackage

// ===== rtl/core/nmea_sentence_framer.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_framer
// frames '$' payload '*' hh CR LF sentences and checks the xor checksum
// ----------------------------------------------------------------------------
// One received byte per item, one status item per byte. The framer hunts for
// '$', forwards each payload byte with its store index, collects the two
// upper-case hex checksum digits, compares them against the xor of the
// payload, then expects CR and LF; the LF item reports sentence done with the
// payload length. Any error, or the overrun flag, returns the framer to the
// hunt for '$'. Throughput is one item per clock while in_stall is low: the
// whole state update is one small decode between the framing registers and
// the result register, and a result register plus one skid entry keep the
// input side running while a result waits. in_stall rises only when both
// result entries are full.
// ----------------------------------------------------------------------------
module nmea_sentence_framer import nsf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_rx_overrun,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_status,
  output logic               out_payload_valid,
  output logic [7:0]         out_payload_byte,
  output logic [INDEX_W-1:0] out_payload_index,
  output logic [COUNT_W-1:0] out_sentence_length
);

  // framing modes
  localparam logic [2:0] MODE_WAIT = 3'd0;
  localparam logic [2:0] MODE_DATA = 3'd1;
  localparam logic [2:0] MODE_HIGH = 3'd2;
  localparam logic [2:0] MODE_LOW  = 3'd3;
  localparam logic [2:0] MODE_CR   = 3'd4;
  localparam logic [2:0] MODE_LF   = 3'd5;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(BUFFER_BYTES);

  // bit 4 flags a byte that is no upper-case hex digit
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] d;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = {1'b0, c[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = {1'b0, c[3:0] + 4'd9};
    end else begin
      d = 5'h10;
    end
    return d;
  endfunction

  // framing state
  logic [2:0]         mode_r, mode_nxt;
  logic [7:0]         xor_r, xor_nxt;
  logic [7:0]         sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  // result register and skid entry
  nsf_result_t res_nxt;
  nsf_result_t out_r, skid_r;
  logic        out_valid_r, skid_valid_r;

  logic       in_accept, out_take;
  logic [4:0] hex_d;
  logic [7:0] sum_full;
  logic [7:0] csum_diff;
  logic       clear;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  assign hex_d     = hex_decode(in_rx_byte);
  // high digit left the low nibble of the sum at zero
  assign sum_full  = sum_r + {4'd0, hex_d[3:0]};
  assign csum_diff = xor_r ^ sum_full;

  // per-byte framing decode
  always_comb begin
    mode_nxt  = mode_r;
    xor_nxt   = xor_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    clear     = 1'b0;
    res_nxt   = '0;

    if (in_rx_overrun) begin
      clear          = 1'b1;
      res_nxt.status = ST_OVERRUN;
    end else begin
      case (mode_r)
        MODE_DATA: begin
          if (in_rx_byte == CH_START) begin
            clear          = 1'b1;
            res_nxt.status = ST_START_UNEXP;
          end else if (in_rx_byte == CH_LF) begin
            clear          = 1'b1;
            res_nxt.status = ST_LF_UNEXP;
          end else if (in_rx_byte == CH_CR) begin
            clear          = 1'b1;
            res_nxt.status = ST_CR_UNEXP;
          end else if (in_rx_byte == CH_STAR) begin
            mode_nxt = MODE_HIGH;
          end else if (count_r >= COUNT_LIMIT) begin
            clear          = 1'b1;
            res_nxt.status = ST_TOO_LONG;
          end else begin
            res_nxt.payload_valid = 1'b1;
            res_nxt.payload_byte  = in_rx_byte;
            res_nxt.payload_index = count_r[INDEX_W-1:0];
            count_nxt             = count_r + COUNT_W'(1);
            xor_nxt               = xor_r ^ in_rx_byte;
          end
        end
        MODE_HIGH: begin
          if (hex_d[4]) begin
            clear          = 1'b1;
            res_nxt.status = ST_BAD_HEX;
          end else begin
            sum_nxt  = {hex_d[3:0], 4'd0};
            mode_nxt = MODE_LOW;
          end
        end
        MODE_LOW: begin
          if (hex_d[4]) begin
            clear          = 1'b1;
            res_nxt.status = ST_BAD_HEX;
          end else begin
            sum_nxt = sum_full;
            xor_nxt = csum_diff;
            if (csum_diff != 8'd0) begin
              clear          = 1'b1;
              res_nxt.status = ST_CSUM_BAD;
            end else begin
              mode_nxt = MODE_CR;
            end
          end
        end
        MODE_CR: begin
          if (in_rx_byte == CH_CR) begin
            mode_nxt = MODE_LF;
          end else begin
            clear          = 1'b1;
            res_nxt.status = ST_CR_EXP;
          end
        end
        MODE_LF: begin
          clear = 1'b1;
          if (in_rx_byte == CH_LF) begin
            res_nxt.status          = ST_DONE;
            res_nxt.sentence_length = count_r;
          end else begin
            res_nxt.status = ST_LF_EXP;
          end
        end
        default: begin
          // hunting for start, unused codes land here too
          if (in_rx_byte == CH_START) begin
            mode_nxt  = MODE_DATA;
            xor_nxt   = 8'd0;
            count_nxt = '0;
          end else begin
            mode_nxt       = MODE_WAIT;
            res_nxt.status = ST_START_EXP;
          end
        end
      endcase
    end

    // framer reset keeps the received checksum
    if (clear) begin
      mode_nxt  = MODE_WAIT;
      xor_nxt   = 8'd0;
      count_nxt = '0;
    end
  end

  // framing registers advance once per accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_WAIT;
      xor_r   <= 8'd0;
      sum_r   <= 8'd0;
      count_r <= '0;
    end else if (in_accept) begin
      mode_r  <= mode_nxt;
      xor_r   <= xor_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

  // result register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      // result slot free: skid entry drains first, in_accept excludes both
      out_valid_r  <= skid_valid_r || in_accept;
      skid_valid_r <= 1'b0;
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_r <= skid_valid_r ? skid_r : res_nxt;
    end
    if (out_valid_r && !out_take && in_accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_r.status;
  assign out_payload_valid   = out_r.payload_valid;
  assign out_payload_byte    = out_r.payload_byte;
  assign out_payload_index   = out_r.payload_index;
  assign out_sentence_length = out_r.sentence_length;

endmodule

// ===== rtl/core/nsf_checker.sv =====
// ----------------------------------------------------------------------------
// nsf_checker
// port-level checks on the result channel of the sentence framer
// ----------------------------------------------------------------------------
module nsf_checker import nsf_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [3:0]         out_status,
  input logic               out_payload_valid,
  input logic [7:0]         out_payload_byte,
  input logic [INDEX_W-1:0] out_payload_index,
  input logic [COUNT_W-1:0] out_sentence_length
);

  // input push-back only while a result is waiting
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_payload_byte) && $stable(out_sentence_length))
    else $error("stalled result changed");

  // stored payload only comes with an ok status
  a_payload_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload_valid |-> out_status == ST_OK)
    else $error("payload byte with non-ok status");

  // length is only reported on sentence done
  a_len_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_sentence_length == '0)
    else $error("sentence length outside sentence done");

  // non-payload results carry zero byte and index
  a_idle_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_valid |-> out_payload_byte == 8'd0
      && out_payload_index == '0)
    else $error("payload fields set without payload");

endmodule

bind nmea_sentence_framer nsf_checker u_nsf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_status          (out_status),
  .out_payload_valid   (out_payload_valid),
  .out_payload_byte    (out_payload_byte),
  .out_payload_index   (out_payload_index),
  .out_sentence_length (out_sentence_length)
);

// ===== sim/nmea_sentence_framer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// byte-level checks of the nmea sentence framer against a cycle-free predictor
// ----------------------------------------------------------------------------
// Bytes go in through a valid/stall sender that works in bursts; every
// accepted byte runs through a local copy of the framing state machine, and
// the status item it should produce is queued. A checker pops that queue on
// every accepted result and compares all five fields. The receiver stalls on
// its own pattern, with one long hold-off so the framer fills up and pushes
// back on its input. A watchdog ends the run if nothing moves for too long.
// ----------------------------------------------------------------------------
module testbench;
  import nsf_pkg::*;

  // run length and timeout, in items and clock cycles
  localparam int TARGET_ITEMS = 1050;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 250;

  // framing state as the predictor tracks it
  typedef enum logic [2:0] {
    HUNT, IN_PAYLOAD, SUM_HIGH, SUM_LOW, WANT_CR, WANT_LF
  } frame_mode_e;

  // ways a generated sentence can be broken on purpose
  typedef enum int {
    FLAW_NONE, FLAW_DELIM, FLAW_OVERRUN, FLAW_CSUM, FLAW_HEX, FLAW_CR, FLAW_LF
  } flaw_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_rx_byte = 8'h00;
  logic               in_rx_overrun = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [3:0]         out_status;
  logic               out_payload_valid;
  logic [7:0]         out_payload_byte;
  logic [INDEX_W-1:0] out_payload_index;
  logic [COUNT_W-1:0] out_sentence_length;

  // predictor state
  frame_mode_e        mode = HUNT;
  logic [7:0]         payload_xor = 8'h00;
  logic [7:0]         received_sum = 8'h00;
  logic [COUNT_W-1:0] payload_count = '0;

  // status items still owed by the framer, oldest first
  nsf_result_t        expected_results[$];

  int                 error_count = 0;
  int                 items_sent = 0;
  int                 burst_left = 0;
  int                 hold_request = 0;

  nmea_sentence_framer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_rx_byte          (in_rx_byte),
    .in_rx_overrun       (in_rx_overrun),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_payload_valid   (out_payload_valid),
    .out_payload_byte    (out_payload_byte),
    .out_payload_index   (out_payload_index),
    .out_sentence_length (out_sentence_length)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  // an error or overrun drops the sentence; the parsed checksum is kept
  function automatic void drop_sentence();
    mode          = HUNT;
    payload_xor   = 8'h00;
    payload_count = '0;
  endfunction

  // upper-case hex digit value, bit 4 set for anything else
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'h10;
  endfunction

  // advance the framing state by one byte and return the status item it gives
  function automatic nsf_result_t frame_byte(input logic [7:0] b, input logic ovr);
    nsf_result_t r;
    logic [4:0]  d;
    r = '0;
    if (ovr) begin
      drop_sentence();
      r.status = ST_OVERRUN;
    end else begin
      case (mode)
        IN_PAYLOAD: begin
          if (b == CH_START) begin
            drop_sentence();
            r.status = ST_START_UNEXP;
          end else if (b == CH_LF) begin
            drop_sentence();
            r.status = ST_LF_UNEXP;
          end else if (b == CH_CR) begin
            drop_sentence();
            r.status = ST_CR_UNEXP;
          end else if (b == CH_STAR) begin
            mode = SUM_HIGH;
          end else if (payload_count >= BUFFER_BYTES) begin
            drop_sentence();
            r.status = ST_TOO_LONG;
          end else begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = payload_count[INDEX_W-1:0];
            payload_count   = payload_count + 1'b1;
            payload_xor     = payload_xor ^ b;
          end
        end
        SUM_HIGH: begin
          d = hex_value(b);
          if (d[4]) begin
            drop_sentence();
            r.status = ST_BAD_HEX;
          end else begin
            received_sum = {d[3:0], 4'h0};
            mode         = SUM_LOW;
          end
        end
        SUM_LOW: begin
          d = hex_value(b);
          if (d[4]) begin
            drop_sentence();
            r.status = ST_BAD_HEX;
          end else begin
            received_sum = received_sum + {4'h0, d[3:0]};
            payload_xor  = payload_xor ^ received_sum;
            if (payload_xor != 8'h00) begin
              drop_sentence();
              r.status = ST_CSUM_BAD;
            end else begin
              mode = WANT_CR;
            end
          end
        end
        WANT_CR: begin
          if (b == CH_CR) begin
            mode = WANT_LF;
          end else begin
            drop_sentence();
            r.status = ST_CR_EXP;
          end
        end
        WANT_LF: begin
          if (b == CH_LF) begin
            r.status          = ST_DONE;
            r.sentence_length = payload_count;
          end else begin
            r.status = ST_LF_EXP;
          end
          drop_sentence();
        end
        default: begin
          if (b == CH_START) begin
            mode          = IN_PAYLOAD;
            payload_xor   = 8'h00;
            payload_count = '0;
          end else begin
            r.status = ST_START_EXP;
          end
        end
      endcase
    end
    return r;
  endfunction

  // ------------------------------------------------------------------ sender

  // offer one byte; bursts of random length with random gaps in between
  task automatic send_byte(input logic [7:0] b, input logic ovr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      // mostly short bursts, now and then a long run with no gaps
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
    end
    in_valid      <= 1'b1;
    in_rx_byte    <= b;
    in_rx_overrun <= ovr;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(frame_byte(b, ovr));
    items_sent++;
    burst_left--;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // any byte that is plain payload
  function automatic logic [7:0] random_payload_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_START || b == CH_STAR || b == CH_LF || b == CH_CR);
    return b;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h41 + 8'(n) - 8'd10;
  endfunction

  // one sentence with random payload, optionally broken in one place
  task automatic send_sentence(input int len, input flaw_e flaw);
    int         cut;
    logic [7:0] sum;
    logic [7:0] b;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [4:0] hv;
    sum = 8'h00;
    cut = $urandom_range(0, len);
    send_byte(CH_START, 1'b0);
    for (int i = 0; i <= len; i++) begin
      if (flaw == FLAW_DELIM && i == cut) begin
        case ($urandom_range(0, 2))
          0:       send_byte(CH_START, 1'b0);
          1:       send_byte(CH_LF, 1'b0);
          default: send_byte(CH_CR, 1'b0);
        endcase
        return;
      end
      if (flaw == FLAW_OVERRUN && i == cut) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
        return;
      end
      if (i < len) begin
        b = random_payload_byte();
        sum ^= b;
        send_byte(b, 1'b0);
      end
    end
    send_byte(CH_STAR, 1'b0);
    if (flaw == FLAW_CSUM) sum ^= 8'($urandom_range(1, 255));
    hi = hex_char(sum[7:4]);
    lo = hex_char(sum[3:0]);
    if (flaw == FLAW_HEX) begin
      // lower-case digit half the time, otherwise any non-hex byte
      if ($urandom_range(0, 1) == 0) b = 8'h61 + 8'($urandom_range(0, 5));
      else begin
        do begin
          b  = 8'($urandom_range(0, 255));
          hv = hex_value(b);
        end while (!hv[4]);
      end
      if ($urandom_range(0, 1) == 0) hi = b;
      else lo = b;
    end
    send_byte(hi, 1'b0);
    send_byte(lo, 1'b0);
    if (flaw == FLAW_CR) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_CR);
      send_byte(b, 1'b0);
    end else begin
      send_byte(CH_CR, 1'b0);
    end
    if (flaw == FLAW_LF) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
      send_byte(b, 1'b0);
    end else begin
      send_byte(CH_LF, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  // stall pattern: quiet, light and heavy stretches, plus an on-demand hold
  int hold_left = 0;
  int stall_mode = 0;
  int stall_mode_left = 0;

  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode      = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(20, 200);
      end
      stall_mode_left--;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ----------------------------------------------------------------- checker

  always @(posedge clk) begin
    nsf_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("status item with none expected: status %0d", out_status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %0d, got %0d",
                 want.payload_valid, out_payload_valid);
          error_count++;
        end
        if (out_payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %h, got %h", want.payload_byte, out_payload_byte);
          error_count++;
        end
        if (out_payload_index !== want.payload_index) begin
          $error("payload_index: expected %0d, got %0d",
                 want.payload_index, out_payload_index);
          error_count++;
        end
        if (out_sentence_length !== want.sentence_length) begin
          $error("sentence_length: expected %0d, got %0d",
                 want.sentence_length, out_sentence_length);
          error_count++;
        end
      end
    end
  end

  // watchdog: cycles in a row with no item moving on either side
  int idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL nmea_sentence_framer");
      $finish;
    end
  end

  // ------------------------------------------------------------------- tests

  // field extremes, a minimal good sentence and several framing errors in short
  task automatic test_directed();
    send_byte(8'h00, 1'b0);              // noise while hunting
    send_byte(8'hFF, 1'b1);              // overrun while hunting
    send_text("$*00\r\n");               // empty payload, checksum zero
    send_text("$");
    send_byte(8'hFF, 1'b0);              // top byte value as payload
    send_byte(CH_START, 1'b0);           // start inside payload
    send_text("$\n");                    // LF inside payload
    send_text("$\r");                    // CR inside payload
    send_text("$*a");                    // lower-case hex is rejected
    send_text("$*01");                   // checksum off by one
    send_text("$V");
    send_byte(8'h00, 1'b1);              // overrun mid-payload
  endtask

  // a full buffer completes; one byte more is too long
  task automatic test_buffer_limit();
    send_sentence(BUFFER_BYTES, FLAW_NONE);
    send_sentence(BUFFER_BYTES + 1, FLAW_NONE);
  endtask

  // long receiver hold-off so the result side fills and stalls the input
  task automatic test_backpressure();
    hold_request = HOLD_CYCLES;
    send_sentence(40, FLAW_NONE);
    send_sentence(12, FLAW_CSUM);
  endtask

  // mostly well-formed sentences, some broken ones, noise and overruns
  task automatic test_random_traffic();
    int    pick;
    int    len;
    flaw_e flaw;
    while (items_sent < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (pick < 12) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 85)      len = $urandom_range(0, 16);
        else if (pick < 97) len = $urandom_range(17, 90);
        else                len = $urandom_range(BUFFER_BYTES - 8, BUFFER_BYTES + 7);
        pick = $urandom_range(0, 99);
        if (pick < 70)      flaw = FLAW_NONE;
        else                flaw = flaw_e'($urandom_range(FLAW_DELIM, FLAW_LF));
        send_sentence(len, flaw);
      end
    end
  endtask

  // -------------------------------------------------------------------- main

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_buffer_limit();
    test_backpressure();
    test_random_traffic();

    // stop offering, drain what is owed, then give stray items time to show
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (error_count == 0) begin
      $display("PASS nmea_sentence_framer");
    end else begin
      $display("FAIL nmea_sentence_framer");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/nsf_pkg.sv
rtl/core/nmea_sentence_framer.sv
rtl/core/nsf_checker.sv
sim/nmea_sentence_framer_tb.sv
